FILE: hdl/dfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_pkg
// Types, constants and helpers shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package dfr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned GAP_W    = 16;
    localparam int unsigned CARD_LEN = 11;
    localparam int unsigned KEY_LEN  = 18;
    localparam int unsigned BANKS    = 2;
    localparam int unsigned DEPTH    = BANKS * KEY_LEN;
    localparam int unsigned ADDR_W   = $clog2(DEPTH);

    localparam logic [BYTE_W-1:0] CARD_HDR0 = 8'hB0;
    localparam logic [BYTE_W-1:0] CARD_HDR1 = 8'h09;
    localparam logic [BYTE_W-1:0] KEY_HDR   = 8'h7E;
    localparam logic [BYTE_W-1:0] KEY_END   = 8'h0D;
    localparam logic [GAP_W-1:0]  GAP_RESET = 16'd100;
    localparam logic [GAP_W-1:0]  GAP_MAX   = '1;

    localparam logic [POS_W-1:0] CARD_LAST = POS_W'(CARD_LEN - 1);
    localparam logic [POS_W-1:0] KEY_LAST  = POS_W'(KEY_LEN - 1);
    localparam logic [POS_W-1:0] KEY_CHK   = POS_W'(KEY_LEN - 2);
    localparam logic [POS_W-1:0] SUM_LAST  = POS_W'(KEY_LEN - 3);

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_CARD = 1'b0;
    localparam logic KIND_KEY  = 1'b1;

    typedef enum logic [1:0] {
        MODE_HUNT  = 2'd0,
        MODE_SAWB0 = 2'd1,
        MODE_CARD  = 2'd2,
        MODE_KEY   = 2'd3
    } t_mode;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_wr;

    typedef struct packed {
        logic start;
        logic kind;
        logic bank;
    } t_emit;

    function automatic logic [ADDR_W-1:0] buf_addr(input logic bank,
                                                   input logic [POS_W-1:0] pos);
        logic [ADDR_W-1:0] base;
        base = bank ? ADDR_W'(KEY_LEN) : '0;
        return base + ADDR_W'(pos);
    endfunction

    // sum values that collide with framing bytes are pulled down by one
    function automatic logic [BYTE_W-1:0] chk_adj(input logic [BYTE_W-1:0] sum);
        if (sum == KEY_HDR || sum == KEY_END) begin
            return sum - 8'd1;
        end
        return sum;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/dfr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_if
// Valid/ready channel interfaces for input items, frame words and config.
// ----------------------------------------------------------------------------
interface dfr_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;
    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface dfr_out_if;
    logic       valid;
    logic       ready;
    logic       frame_kind;
    logic [4:0] byte_pos;
    logic [7:0] frame_byte;
    logic       last;
    modport source (output valid, output frame_kind, output byte_pos,
                    output frame_byte, output last, input ready);
    modport sink   (input valid, input frame_kind, input byte_pos,
                    input frame_byte, input last, output ready);
endinterface

interface dfr_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/dual_format_serial_frame_receiver_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_format_serial_frame_receiver_core
// Card / keypad frame receiver for a serial byte stream with ms ticks.
// ----------------------------------------------------------------------------
// i_in carries one word per serial byte (op 0) or millisecond tick (op 1).
// i_cfg writes gap_limit (reset 100); it is always ready.
// o_out emits each accepted frame as one word per byte, byte_pos 0 first,
// last set on the final byte: 11 words for a card frame, 18 for keypad.
// Input is taken at one word per cycle. Each collected byte is written
// into one bank of a two-bank frame memory; the byte that closes an accepted
// frame starts a drain sequencer that reads it back at one word per cycle
// through the memory's read port, the read register and the output register.
// While a frame drains, the next frame collects in the other bank; only a
// byte that could close a frame waits (ready low) until the drain has
// issued its last read. o_out stalls hold the output register and the
// drain; input keeps flowing except for that closing byte.
// Reset clears the hunt state, gap timer and drain; memory is not cleared.
// ----------------------------------------------------------------------------
module dual_format_serial_frame_receiver_core
    import dfr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dfr_in_if.sink     i_in,
    dfr_cfg_if.sink    i_cfg,
    dfr_out_if.source  o_out
);

    t_wr   wr;
    t_emit emit;
    logic  busy;

    assign i_cfg.ready = 1'b1;

    dfr_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .i_op       (i_in.op),
        .i_rx_byte  (i_in.rx_byte),
        .i_busy     (busy),
        .o_ready    (i_in.ready),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .o_wr       (wr),
        .o_emit     (emit)
    );

    dfr_frame_buf u_frame_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_emit      (emit),
        .o_busy      (busy),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_kind  (o_out.frame_kind),
        .o_out_pos   (o_out.byte_pos),
        .o_out_byte  (o_out.frame_byte),
        .o_out_last  (o_out.last)
    );

endmodule
`default_nettype wire

FILE: hdl/dfr_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_parser
// Header hunt, byte collection, keypad checksum and gap timer.
// ----------------------------------------------------------------------------
module dfr_parser
    import dfr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_op,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    input  wire logic              i_busy,
    output logic                   o_ready,
    input  wire logic              i_cfg_we,
    input  wire logic [GAP_W-1:0]  i_cfg_data,
    output t_wr                    o_wr,
    output t_emit                  o_emit
);

    t_mode             r_mode, n_mode;
    logic [POS_W-1:0]  r_cnt, n_cnt;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [GAP_W-1:0]  r_gap, n_gap;
    logic [GAP_W-1:0]  r_gap_limit;
    logic              r_chk_ok, n_chk_ok;
    logic              r_bank, n_bank;

    logic              accept;
    logic              closing;
    t_mode             mode_e;
    logic [POS_W-1:0]  cnt_e;
    logic [BYTE_W-1:0] sum_e;
    logic [BYTE_W-1:0] b;

    // a byte that may close a frame waits until the drain has freed its bank
    assign closing = (r_mode == MODE_CARD && r_cnt == CARD_LAST) ||
                     (r_mode == MODE_KEY && r_cnt == KEY_LAST);
    assign o_ready = !(i_busy && closing);
    assign accept  = i_valid && o_ready;
    assign b       = i_rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_HUNT;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_gap       <= '0;
            r_gap_limit <= GAP_RESET;
            r_chk_ok    <= 1'b0;
            r_bank      <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_cnt    <= n_cnt;
            r_sum    <= n_sum;
            r_gap    <= n_gap;
            r_chk_ok <= n_chk_ok;
            r_bank   <= n_bank;
            if (i_cfg_we) begin
                r_gap_limit <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_cnt    = r_cnt;
        n_sum    = r_sum;
        n_gap    = r_gap;
        n_chk_ok = r_chk_ok;
        n_bank   = r_bank;
        o_wr     = '{en: 1'b0, addr: buf_addr(r_bank, r_cnt), data: b};
        o_emit   = '{start: 1'b0, kind: KIND_CARD, bank: r_bank};
        mode_e   = r_mode;
        cnt_e    = r_cnt;
        sum_e    = r_sum;

        if (accept && i_op == OP_TICK) begin
            if (r_gap != GAP_MAX) begin
                n_gap = r_gap + GAP_W'(1);
            end
        end else if (accept) begin
            if (r_gap >= r_gap_limit) begin
                mode_e = MODE_HUNT;
                cnt_e  = '0;
                sum_e  = '0;
            end
            n_gap     = '0;
            n_sum     = '0;
            o_wr.addr = buf_addr(r_bank, cnt_e);

            unique case (mode_e)
                MODE_SAWB0, MODE_HUNT: begin
                    if (mode_e == MODE_SAWB0 && b == CARD_HDR1) begin
                        o_wr.en   = 1'b1;
                        o_wr.addr = buf_addr(r_bank, POS_W'(1));
                        n_cnt     = POS_W'(2);
                        n_mode    = MODE_CARD;
                    end else if (b == CARD_HDR0 || b == KEY_HDR) begin
                        o_wr.en   = 1'b1;
                        o_wr.addr = buf_addr(r_bank, '0);
                        n_cnt     = POS_W'(1);
                        n_mode    = (b == KEY_HDR) ? MODE_KEY : MODE_SAWB0;
                    end else begin
                        n_cnt  = '0;
                        n_mode = MODE_HUNT;
                    end
                end
                MODE_CARD: begin
                    o_wr.en = 1'b1;
                    n_cnt   = cnt_e + POS_W'(1);
                    if (cnt_e == CARD_LAST) begin
                        n_cnt        = '0;
                        n_mode       = MODE_HUNT;
                        o_emit.start = 1'b1;
                        o_emit.kind  = KIND_CARD;
                        n_bank       = !r_bank;
                    end
                end
                MODE_KEY: begin
                    o_wr.en = 1'b1;
                    n_cnt   = cnt_e + POS_W'(1);
                    n_sum   = (cnt_e != '0 && cnt_e <= SUM_LAST) ? sum_e + b : sum_e;
                    if (cnt_e == KEY_CHK) begin
                        n_chk_ok = (b == chk_adj(sum_e));
                    end
                    if (cnt_e == KEY_LAST) begin
                        n_cnt  = '0;
                        n_sum  = '0;
                        n_mode = MODE_HUNT;
                        if (b == KEY_END && r_chk_ok) begin
                            o_emit.start = 1'b1;
                            o_emit.kind  = KIND_KEY;
                            n_bank       = !r_bank;
                        end
                    end
                end
                default: begin
                    n_mode = MODE_HUNT;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: hdl/dfr_frame_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_frame_buf
// Two-bank frame memory, drain sequencer and output register.
// ----------------------------------------------------------------------------
module dfr_frame_buf
    import dfr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_wr               i_wr,
    input  wire t_emit             i_emit,
    output logic                   o_busy,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_out_kind,
    output logic [POS_W-1:0]       o_out_pos,
    output logic [BYTE_W-1:0]      o_out_byte,
    output logic                   o_out_last
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] r_q;

    logic              r_active;
    logic              r_rbank;
    logic              r_kind;
    logic [POS_W-1:0]  r_rpos;
    logic [POS_W-1:0]  r_rlast;

    logic              r_s1_v;
    logic              r_s1_kind;
    logic [POS_W-1:0]  r_s1_pos;
    logic              r_s1_last;

    logic              r_o_v;
    logic              r_o_kind;
    logic [POS_W-1:0]  r_o_pos;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_last;

    logic              mv;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    assign mv      = r_s1_v && (!r_o_v || i_out_ready);
    assign rd_en   = r_active && (!r_s1_v || mv);
    assign rd_addr = buf_addr(r_rbank, r_rpos);
    assign o_busy  = r_active;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (rd_en) begin
            r_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_s1_v   <= 1'b0;
            r_o_v    <= 1'b0;
        end else begin
            if (i_emit.start) begin
                r_active <= 1'b1;
            end else if (rd_en && r_rpos == r_rlast) begin
                r_active <= 1'b0;
            end
            r_s1_v <= rd_en || (r_s1_v && !mv);
            r_o_v  <= mv || (r_o_v && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.start) begin
            r_rbank <= i_emit.bank;
            r_kind  <= i_emit.kind;
            r_rpos  <= '0;
            r_rlast <= (i_emit.kind == KIND_KEY) ? KEY_LAST : CARD_LAST;
        end else if (rd_en) begin
            r_rpos <= r_rpos + POS_W'(1);
        end
        if (rd_en) begin
            r_s1_kind <= r_kind;
            r_s1_pos  <= r_rpos;
            r_s1_last <= (r_rpos == r_rlast);
        end
        if (mv) begin
            r_o_kind <= r_s1_kind;
            r_o_pos  <= r_s1_pos;
            r_o_byte <= r_q;
            r_o_last <= r_s1_last;
        end
    end

    assign o_out_valid = r_o_v;
    assign o_out_kind  = r_o_kind;
    assign o_out_pos   = r_o_pos;
    assign o_out_byte  = r_o_byte;
    assign o_out_last  = r_o_last;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_emit.start |-> !r_active)
        else $error("frame drain started while busy");

    a_rose_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_active) |-> $past(i_emit.start))
        else $error("drain became active without a frame");

    a_bank_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr.en && rd_en) |-> (i_wr.addr != rd_addr))
        else $error("collection wrote the entry being drained");

endmodule
`default_nettype wire

FILE: sim/tb_dual_format_serial_frame_receiver_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_format_serial_frame_receiver_core
// Self-checking bench for the card / keypad frame receiver. A queue of
// serial bytes and ms ticks feeds a bursty valid/ready driver; every
// accepted item runs through a behavioral copy of the hunt/collect logic,
// which queues the frame words due on o_out. A monitor with its own stall
// pattern compares each output word against the oldest one queued. The
// run walks gap_limit through its reset value, one, zero, the maximum and a
// random setting.
// ----------------------------------------------------------------------------
module tb_dual_format_serial_frame_receiver_core;
    import dfr_pkg::*;

    localparam int LIMIT     = 2_000_000;
    localparam int HOLD_AT   = 220;
    localparam int HOLD_LEN  = 300;
    localparam int NEAR_GAP  = 300;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic       kind;
        logic [4:0] pos;
        logic [7:0] data;
        logic       last;
    } t_word;

    typedef enum int {
        KP_GOOD,
        KP_BAD_SUM,
        KP_BAD_END,
        KP_SUM_HDR,
        KP_SUM_END
    } t_flaw;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dfr_in_if  link_if ();
    dfr_cfg_if cfg_if ();
    dfr_out_if word_if ();

    dual_format_serial_frame_receiver_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (link_if),
        .i_cfg   (cfg_if),
        .o_out   (word_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // stimulus and expected words
    t_item serial_items[$];
    t_word frame_words_due[$];
    int    queued         = 0;
    int    items_accepted = 0;
    int    errors         = 0;
    int    cycles         = 0;
    int    tick_odds      = 0;
    int    gap_set        = 100;

    // behavioral state of the receiver
    logic [15:0] lim_gap;
    logic [7:0]  seen_buf [KEY_LEN];
    logic [4:0]  seen_cnt;
    t_mode       seen_mode;
    logic [7:0]  seen_sum;
    logic [15:0] idle_ticks;

    // driver / monitor bookkeeping
    t_item nxt;
    int    burst_left  = 0;
    int    gap_left    = 0;
    int    hold_left   = 0;
    logic  hold_done   = 1'b0;
    int    stall_style = 0;
    int    style_left  = 0;
    logic  go;
    t_word got;
    t_word want;

    task automatic flag_mismatch(input string note);
        $display("mismatch @%0t: %s", $time, note);
        errors++;
    endtask

    task automatic restart_hunt();
        seen_mode = MODE_HUNT;
        seen_cnt  = '0;
        seen_sum  = '0;
    endtask

    task automatic take_header(input logic [7:0] b);
        restart_hunt();
        if (b == CARD_HDR0) begin
            seen_buf[0] = b;
            seen_cnt    = 5'd1;
            seen_mode   = MODE_SAWB0;
        end else if (b == KEY_HDR) begin
            seen_buf[0] = b;
            seen_cnt    = 5'd1;
            seen_mode   = MODE_KEY;
        end
    endtask

    task automatic queue_frame(input logic kind, input int len);
        t_word w;
        for (int k = 0; k < len; k++) begin
            w.kind = kind;
            w.pos  = 5'(k);
            w.data = seen_buf[k];
            w.last = (k == len - 1);
            frame_words_due.push_back(w);
        end
    endtask

    // one accepted item through the hunt / collect logic
    task automatic track_link_item(input logic op, input logic [7:0] b);
        logic [7:0] chk;
        if (op == OP_TICK) begin
            if (idle_ticks != GAP_MAX) idle_ticks++;
            return;
        end
        if (idle_ticks >= lim_gap) restart_hunt();
        idle_ticks = '0;
        case (seen_mode)
            MODE_SAWB0: begin
                if (b == CARD_HDR1) begin
                    seen_buf[1] = b;
                    seen_cnt    = 5'd2;
                    seen_mode   = MODE_CARD;
                end else begin
                    take_header(b);
                end
            end
            MODE_CARD: begin
                if (seen_cnt >= CARD_LEN) begin
                    take_header(b);
                end else begin
                    seen_buf[seen_cnt] = b;
                    seen_cnt++;
                    if (seen_cnt == CARD_LEN) begin
                        restart_hunt();
                        queue_frame(KIND_CARD, CARD_LEN);
                    end
                end
            end
            MODE_KEY: begin
                if (seen_cnt >= KEY_LEN) begin
                    take_header(b);
                end else begin
                    seen_buf[seen_cnt] = b;
                    if (seen_cnt >= 1 && seen_cnt <= 15) seen_sum += b;
                    seen_cnt++;
                    if (seen_cnt == KEY_LEN) begin
                        chk = seen_sum;
                        if (chk == KEY_HDR || chk == KEY_END) chk = chk - 8'd1;
                        restart_hunt();
                        if (seen_buf[17] == KEY_END && seen_buf[16] == chk)
                            queue_frame(KIND_KEY, KEY_LEN);
                    end
                end
            end
            default: take_header(b);
        endcase
    endtask

    // ---------------- stimulus builders ----------------
    task automatic add_byte(input logic [7:0] b);
        t_item it;
        it.op      = OP_BYTE;
        it.rx_byte = b;
        serial_items.push_back(it);
        queued++;
    endtask

    task automatic add_ticks(input int n);
        t_item it;
        for (int k = 0; k < n; k++) begin
            it.op      = OP_TICK;
            it.rx_byte = 8'($urandom);
            serial_items.push_back(it);
            queued++;
        end
    endtask

    // silence inside a frame, sometimes right at the gap boundary
    task automatic maybe_ticks();
        if ($urandom_range(0, 99) < tick_odds) begin
            if (gap_set <= NEAR_GAP && $urandom_range(0, 1) == 1)
                add_ticks(gap_set - int'($urandom_range(0, 1)));
            else
                add_ticks($urandom_range(1, 3));
        end
    endtask

    task automatic add_card();
        add_byte(CARD_HDR0);
        maybe_ticks();
        add_byte(CARD_HDR1);
        for (int k = 2; k < CARD_LEN; k++) begin
            maybe_ticks();
            add_byte(8'($urandom));
        end
    endtask

    task automatic add_keypad(input t_flaw flaw);
        logic [7:0] body [KEY_LEN];
        logic [7:0] sum;
        body[0] = KEY_HDR;
        sum = '0;
        for (int k = 1; k <= 15; k++) begin
            body[k] = 8'($urandom);
            if (k < 15) sum += body[k];
        end
        // steer the sum onto a framing byte to hit the pull-down
        if (flaw == KP_SUM_HDR) body[15] = KEY_HDR - sum;
        if (flaw == KP_SUM_END) body[15] = KEY_END - sum;
        sum += body[15];
        if (sum == KEY_HDR || sum == KEY_END) sum = sum - 8'd1;
        body[16] = sum;
        body[17] = KEY_END;
        if (flaw == KP_BAD_SUM) body[16] = sum ^ (8'd1 << $urandom_range(0, 7));
        if (flaw == KP_BAD_END) body[17] = KEY_END ^ (8'd1 << $urandom_range(0, 7));
        for (int k = 0; k < KEY_LEN; k++) begin
            if (k != 0) maybe_ticks();
            add_byte(body[k]);
        end
    endtask

    task automatic gen_random(input int n);
        int stop;
        int r;
        int len;
        stop = queued + n;
        while (queued < stop) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                case ($urandom_range(0, 5))
                    0:       add_keypad(KP_SUM_HDR);
                    1:       add_keypad(KP_SUM_END);
                    default: add_keypad(KP_GOOD);
                endcase
            end else if (r < 65) begin
                add_card();
            end else if (r < 75) begin
                add_keypad($urandom_range(0, 1) ? KP_BAD_SUM : KP_BAD_END);
            end else if (r < 82) begin
                // frame cut short, then, for a small gap_limit, silence to break it off
                add_byte($urandom_range(0, 1) ? CARD_HDR0 : KEY_HDR);
                len = $urandom_range(0, 8);
                for (int k = 0; k < len; k++) add_byte(8'($urandom));
                if (gap_set <= NEAR_GAP) add_ticks(gap_set);
            end else if (r < 88) begin
                add_byte(CARD_HDR0);
                add_byte(8'($urandom));
            end else if (r < 95) begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) add_byte(8'($urandom));
            end else if (gap_set <= NEAR_GAP) begin
                len = gap_set + int'($urandom_range(0, 2)) - 1;
                add_ticks(len < 1 ? 1 : len);
            end else begin
                add_ticks($urandom_range(1, 40));
            end
        end
    endtask

    // sampled on the falling edge so queue and valid are settled
    task automatic settle_link();
        @(negedge i_clk);
        while (serial_items.size() != 0 || link_if.valid || frame_words_due.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_gap_limit(input logic [15:0] v);
        settle_link();
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        lim_gap = v;
        gap_set = v;
        cfg_if.valid <= 1'b0;
    endtask

    // ---------------- sender: bursts with random gaps ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            link_if.valid   <= 1'b0;
            link_if.op      <= OP_BYTE;
            link_if.rx_byte <= '0;
        end else begin
            if (link_if.valid && link_if.ready) begin
                track_link_item(link_if.op, link_if.rx_byte);
                items_accepted <= items_accepted + 1;
            end
            if (!link_if.valid || link_if.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    link_if.valid <= 1'b0;
                end else if (serial_items.size() != 0) begin
                    nxt = serial_items.pop_front();
                    link_if.valid   <= 1'b1;
                    link_if.op      <= nxt.op;
                    link_if.rx_byte <= nxt.rx_byte;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    link_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off once traffic is flowing, so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && items_accepted >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // ---------------- receiver: checks each word, stalls by style ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            word_if.ready <= 1'b0;
        end else begin
            if (word_if.valid && word_if.ready) begin
                got.kind = word_if.frame_kind;
                got.pos  = word_if.byte_pos;
                got.data = word_if.frame_byte;
                got.last = word_if.last;
                if (frame_words_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word kind %0d pos %0d byte %h last %0d",
                                            got.kind, got.pos, got.data, got.last));
                end else begin
                    want = frame_words_due.pop_front();
                    if (got !== want)
                        flag_mismatch($sformatf(
                            "got kind %0d pos %0d byte %h last %0d, want %0d %0d %h %0d",
                            got.kind, got.pos, got.data, got.last,
                            want.kind, want.pos, want.data, want.last));
                end
            end
            if (style_left == 0) begin
                stall_style = $urandom_range(0, 3);
                style_left  = $urandom_range(16, 128);
            end else begin
                style_left--;
            end
            case (stall_style)
                0:       go = 1'b1;
                1:       go = ($urandom_range(0, 3) != 0);
                2:       go = ($urandom_range(0, 2) == 0);
                default: go = ((style_left % 4) != 0);
            endcase
            word_if.ready <= (hold_left == 0) && go;
        end
    end

    initial begin
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        cfg_if.valid    = 1'b0;
        cfg_if.data     = '0;
        lim_gap         = GAP_RESET;
        idle_ticks      = '0;
        restart_hunt();

        // directed: noise, B0 then keypad, card with extreme bytes, B0 then junk,
        // partial card dropped by a full gap and the next header taken
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(CARD_HDR0);
        add_keypad(KP_SUM_HDR);
        add_byte(CARD_HDR0);
        add_byte(CARD_HDR0);
        add_byte(CARD_HDR1);
        for (int k = 2; k < CARD_LEN; k++) add_byte(k[0] ? 8'hFF : 8'h00);
        add_byte(CARD_HDR0);
        add_byte(8'h55);
        add_byte(CARD_HDR0);
        add_byte(CARD_HDR1);
        add_byte(8'hA5);
        add_ticks(100);
        add_card();
        add_keypad(KP_SUM_END);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tick_odds = 10;
        gen_random(60);

        write_gap_limit(16'd1);
        gen_random(40);

        // zero limit: every byte drops what was collected
        write_gap_limit(16'd0);
        tick_odds = 0;
        add_card();
        add_keypad(KP_GOOD);

        write_gap_limit(16'hFFFF);
        tick_odds = 10;
        gen_random(40);

        write_gap_limit(16'($urandom_range(2, 40)));
        gen_random(40);

        write_gap_limit(GAP_RESET);
        gen_random(40);

        settle_link();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
